[design/jtm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jtm_pkg: shared definitions for the joystick to tank drive mixer
// Field widths, pipeline depth, fixed-point constants and the arctangent
// step table used by the mixer pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package jtm_pkg;

   // Channel field widths.
   localparam int JOY_W   = 8;
   localparam int SPEED_W = 16;

   // Fractional bits of the track speed outputs.
   localparam int OUT_FRAC_BITS = 14;

   // Number of CORDIC vectoring stages.
   localparam int ANGLE_STAGES = 16;

   // Joystick saturation bound and magnitude bits after saturation.
   localparam logic signed [JOY_W-1:0] JOY_MAX = 8'sd100;
   localparam logic signed [JOY_W-1:0] JOY_MIN = -8'sd100;
   localparam int AX_W = 7;

   // Squared magnitude; at or above full deflection the scale is one.
   localparam int MSQ_W    = 15;
   localparam int MSQ_LO_W = 14;
   localparam logic [MSQ_W-1:0] MSQ_FULL = 15'd10000;

   // Scale radicand floor(msq * 2^44 / 625) = msq * Q + floor(41 * msq / 625).
   // The remainder term uses a reciprocal multiply by ceil(2^29 / 625).
   localparam int Q_W = 35;
   localparam logic [Q_W-1:0] RECIP_Q = 35'd28147497671;
   localparam int V_W = 20;
   localparam logic [V_W-1:0] REM_MUL = 20'd41;
   localparam int M_W = 20;
   localparam logic [M_W-1:0] RECIP_M = 20'd858994;
   localparam int RECIP_SHIFT = 29;
   localparam int P_W  = MSQ_LO_W + Q_W;
   localparam int PM_W = V_W + M_W;

   // Square root: one result bit per stage.
   localparam int SQRT_STAGES = 24;
   localparam int N_W = 2 * SQRT_STAGES;
   localparam int K_W = SQRT_STAGES + 1;
   localparam logic [K_W-1:0] K_FULL = K_W'(1) << SQRT_STAGES;

   // Iteration stages are shared by the CORDIC and the square root.
   localparam int ITER_STAGES = (ANGLE_STAGES > SQRT_STAGES) ? ANGLE_STAGES : SQRT_STAGES;

   // Whole pipeline: saturate, radicand product, radicand sum, iterations,
   // segment map, speed product, rounding.
   localparam int PIPE_DEPTH = ITER_STAGES + 6;

   // CORDIC datapath.
   localparam int PRE_SHIFT = 20;
   localparam int CX_W = 30;
   localparam int Z_W  = 32;

   // Angle fraction: a quarter turn is 2^TURN_BITS.
   localparam int TURN_BITS = 30;
   localparam int T_W  = TURN_BITS + 1;
   localparam int T3_W = TURN_BITS + 2;
   localparam int UNIT_W = TURN_BITS + 2;
   localparam int WORK_W = TURN_BITS + 4;
   localparam logic [T_W-1:0] QUARTER_T = T_W'(1) << TURN_BITS;
   localparam logic [T3_W-1:0] QUARTER_T3 = T3_W'(1) << TURN_BITS;
   localparam logic [T3_W-1:0] HALF_T3 = T3_W'(1) << (TURN_BITS + 1);
   localparam logic signed [Z_W-1:0] QUARTER_Z = Z_W'(1) << TURN_BITS;
   localparam logic signed [UNIT_W-1:0] QUARTER_U = UNIT_W'(1) << TURN_BITS;
   localparam logic signed [WORK_W-1:0] QUARTER_W = WORK_W'(1) << TURN_BITS;

   // Speed product and the rounding shift back to the output format.
   localparam int PROD_W = UNIT_W + K_W + 1;
   localparam int SCALE_SHIFT = TURN_BITS + SQRT_STAGES - OUT_FRAC_BITS;

   // Arctangent of 2^-i in units of 2^32 per full turn.
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Quadrant and special case flags that travel with each sample.
   typedef struct packed {
      logic x_neg;
      logic x_pos;
      logic y_neg;
      logic ay_zero;
      logic k_full;
   } flags_type;

   // State of one sample inside the iteration stages.
   typedef struct packed {
      logic signed [CX_W-1:0] cx;
      logic signed [CX_W-1:0] cy;
      logic signed [Z_W-1:0]  z;
      logic [N_W-1:0]         rem;
      logic [N_W-1:0]         root;
      flags_type              flags;
   } iter_type;

   // Clamp a raw joystick reading to the legal deflection range.
   function automatic logic signed [JOY_W-1:0] sat_joy(input logic signed [JOY_W-1:0] raw);
      logic signed [JOY_W-1:0] v;
      v = raw;
      if (raw > JOY_MAX) begin
         v = JOY_MAX;
      end else if (raw < JOY_MIN) begin
         v = JOY_MIN;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

[design/jtm_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jtm_if: channel interfaces of the joystick to tank drive mixer
// A joystick sample channel and a track speed channel, each with a
// valid/ready handshake and a source and a sink view.
// ----------------------------------------------------------------------------

// Joystick sample channel.
interface jtm_req_if import jtm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [JOY_W-1:0] joy_x;
   logic signed [JOY_W-1:0] joy_y;

   modport source (output valid, output joy_x, output joy_y, input ready);
   modport sink   (input valid, input joy_x, input joy_y, output ready);
endinterface

// Track speed channel.
interface jtm_rsp_if import jtm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] left_speed;
   logic signed [SPEED_W-1:0] right_speed;

   modport source (output valid, output left_speed, output right_speed, input ready);
   modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface
`default_nettype wire

[design/joystick_to_tank_drive_mixer_unit.sv]
// An accepted sample passes stages A, B and C, the iteration stages and stages D, E and F to its speed pair.
// Throughput: one transaction per cycle while the result side is ready.
// The depth is set by the shared CORDIC and square root iteration stages, one step each.
// A stall on the result side holds the whole pipeline in place.
// Reset clears only the stage valid bits; no clearing pass is needed.
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_to_tank_drive_mixer_unit: joystick to differential drive mixer
// Turns a saturated joystick sample into left and right track speeds by a
// pipelined CORDIC angle, a pipelined square root scale and a segment map.
// ----------------------------------------------------------------------------
module joystick_to_tank_drive_mixer_unit import jtm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   jtm_req_if.sink    req_if,
   jtm_rsp_if.source  rsp_if
);

   // Pipeline advance: the whole pipeline moves unless the result is stalled.
   logic en;
   logic [PIPE_DEPTH-1:0] valid_ff;

   assign en = !valid_ff[PIPE_DEPTH-1] || rsp_if.ready;
   assign req_if.ready = en;

   // Valid bits travel in step with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_if.valid};
      end
   end

   // Stage A: saturate, take magnitudes, squared magnitude and flags.
   logic [AX_W-1:0]  a_ax_ff, a_ay_ff, a_ax_in, a_ay_in;
   logic [MSQ_W-1:0] a_msq_ff, a_msq_in;
   flags_type        a_flags_ff, a_flags_in;

   always_comb begin
      logic signed [JOY_W-1:0] sx, sy, nx, ny;
      sx = sat_joy(req_if.joy_x);
      sy = sat_joy(req_if.joy_y);
      nx = -sx;
      ny = -sy;
      a_ax_in = sx[JOY_W-1] ? nx[AX_W-1:0] : sx[AX_W-1:0];
      a_ay_in = sy[JOY_W-1] ? ny[AX_W-1:0] : sy[AX_W-1:0];
      a_msq_in = MSQ_W'(a_ax_in) * MSQ_W'(a_ax_in) + MSQ_W'(a_ay_in) * MSQ_W'(a_ay_in);
      a_flags_in.x_neg   = sx[JOY_W-1];
      a_flags_in.x_pos   = !sx[JOY_W-1] && (sx != '0);
      a_flags_in.y_neg   = sy[JOY_W-1];
      a_flags_in.ay_zero = (sy == '0);
      a_flags_in.k_full  = (a_msq_in >= MSQ_FULL);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ax_ff    <= a_ax_in;
         a_ay_ff    <= a_ay_in;
         a_msq_ff   <= a_msq_in;
         a_flags_ff <= a_flags_in;
      end
   end

   // Stage B: main radicand product, remainder numerator, CORDIC start vector.
   logic [N_W-1:0]         b_p_ff, b_p_in;
   logic [V_W-1:0]         b_v_ff, b_v_in;
   logic signed [CX_W-1:0] b_cx_ff, b_cy_ff, b_cx_in, b_cy_in;
   flags_type              b_flags_ff;

   always_comb begin
      logic [MSQ_LO_W-1:0] msq_lo;
      logic [P_W-1:0]      prod;
      msq_lo  = a_msq_ff[MSQ_LO_W-1:0];
      prod    = P_W'(msq_lo) * P_W'(RECIP_Q);
      b_p_in  = prod[N_W-1:0];
      b_v_in  = V_W'(msq_lo) * REM_MUL;
      b_cx_in = {{(CX_W-AX_W-PRE_SHIFT){1'b0}}, a_ax_ff, {PRE_SHIFT{1'b0}}};
      b_cy_in = {{(CX_W-AX_W-PRE_SHIFT){1'b0}}, a_ay_ff, {PRE_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_p_ff     <= b_p_in;
         b_v_ff     <= b_v_in;
         b_cx_ff    <= b_cx_in;
         b_cy_ff    <= b_cy_in;
         b_flags_ff <= a_flags_ff;
      end
   end

   // Stage C: finish the radicand and load the iteration state.
   iter_type c_ff, c_in;

   always_comb begin
      logic [PM_W-1:0] rprod;
      rprod       = PM_W'(b_v_ff) * PM_W'(RECIP_M);
      c_in.cx     = b_cx_ff;
      c_in.cy     = b_cy_ff;
      c_in.z      = '0;
      c_in.rem    = b_p_ff + N_W'(rprod >> RECIP_SHIFT);
      c_in.root   = '0;
      c_in.flags  = b_flags_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
      end
   end

   // Iteration stages: one square root bit each, and one CORDIC rotation in each of the first ANGLE_STAGES.
   iter_type iter_ff [ITER_STAGES];

   for (genvar i = 0; i < ITER_STAGES; i++) begin : g_iter
      iter_type               prev;
      iter_type               iter_in;
      logic signed [CX_W-1:0] cx_in, cy_in;
      logic signed [Z_W-1:0]  z_in;
      logic [N_W-1:0]         rem_in, root_in;

      if (i == 0) begin : g_first
         assign prev = c_ff;
      end else begin : g_next
         assign prev = iter_ff[i-1];
      end

      // Rotate toward the x axis and accumulate the angle.
      if (i < ANGLE_STAGES) begin : g_cordic
         localparam logic signed [Z_W-1:0] STEP = Z_W'(ATAN_TABLE[i]);
         always_comb begin
            logic signed [CX_W-1:0] cx, cy, dx, dy;
            cx = prev.cx;
            cy = prev.cy;
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
               cx_in = cx + dx;
               cy_in = cy - dy;
               z_in  = prev.z + STEP;
            end else begin
               cx_in = cx - dx;
               cy_in = cy + dy;
               z_in  = prev.z - STEP;
            end
         end
      end else begin : g_cordic_hold
         assign cx_in = prev.cx;
         assign cy_in = prev.cy;
         assign z_in  = prev.z;
      end

      // Restoring square root, one result bit per stage.
      if (i < SQRT_STAGES) begin : g_sqrt
         localparam logic [N_W-1:0] BIT = N_W'(1) << (N_W - 2 - 2 * i);
         always_comb begin
            logic [N_W:0] trial;
            trial = {1'b0, prev.root} + {1'b0, BIT};
            if ({1'b0, prev.rem} >= trial) begin
               rem_in  = prev.rem - trial[N_W-1:0];
               root_in = (prev.root >> 1) + BIT;
            end else begin
               rem_in  = prev.rem;
               root_in = prev.root >> 1;
            end
         end
      end else begin : g_sqrt_hold
         assign rem_in  = prev.rem;
         assign root_in = prev.root;
      end

      always_comb begin
         iter_in.cx    = cx_in;
         iter_in.cy    = cy_in;
         iter_in.z     = z_in;
         iter_in.rem   = rem_in;
         iter_in.root  = root_in;
         iter_in.flags = prev.flags;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            iter_ff[i] <= iter_in;
         end
      end
   end

   // Stage D: angle fraction, scale and the per-quadrant segment map.
   iter_type                 last;
   logic signed [UNIT_W-1:0] d_l_ff, d_r_ff, d_l_in, d_r_in;
   logic [K_W-1:0]           d_k_ff, d_k_in;

   assign last = iter_ff[ITER_STAGES-1];

   always_comb begin
      logic [T_W-1:0]           t;
      logic [T3_W-1:0]          t3;
      logic signed [WORK_W-1:0] ts, t3s, two_t, seg_a, seg_b, l_w, r_w;
      logic                     ax_zero;
      ax_zero = !last.flags.x_neg && !last.flags.x_pos;
      if (ax_zero) begin
         t = QUARTER_T;
      end else if (last.flags.ay_zero) begin
         t = '0;
      end else if (last.z < 0) begin
         t = '0;
      end else if (last.z > QUARTER_Z) begin
         t = QUARTER_T;
      end else begin
         t = last.z[T_W-1:0];
      end
      t3    = {1'b0, t} + {t, 1'b0};
      ts    = {{(WORK_W-T_W){1'b0}}, t};
      t3s   = {{(WORK_W-T3_W){1'b0}}, t3};
      two_t = (ts <<< 1) - QUARTER_W;

      // Lower half: spin, pivot and reverse segments.
      if (t3 < QUARTER_T3) begin
         seg_a = t3s - QUARTER_W;
         seg_b = QUARTER_W - t3s;
      end else if (t3 < HALF_T3) begin
         seg_a = '0;
         seg_b = QUARTER_W - t3s;
      end else begin
         seg_a = (QUARTER_W <<< 1) - t3s;
         seg_b = -QUARTER_W;
      end

      if (!last.flags.y_neg) begin
         if (!last.flags.x_neg) begin
            l_w = QUARTER_W;
            r_w = two_t;
         end else begin
            l_w = two_t;
            r_w = QUARTER_W;
         end
      end else if (!last.flags.x_pos) begin
         l_w = seg_a;
         r_w = seg_b;
      end else begin
         l_w = seg_b;
         r_w = seg_a;
      end
      d_l_in = l_w[UNIT_W-1:0];
      d_r_in = r_w[UNIT_W-1:0];
      d_k_in = last.flags.k_full ? K_FULL : last.root[K_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_l_ff <= d_l_in;
         d_r_ff <= d_r_in;
         d_k_ff <= d_k_in;
      end
   end

   // Stage E: scale both unit speeds by the magnitude.
   logic signed [PROD_W-1:0] e_pl_ff, e_pr_ff, e_pl_in, e_pr_in;

   always_comb begin
      logic signed [K_W:0] ks;
      ks      = {1'b0, d_k_ff};
      e_pl_in = PROD_W'(d_l_ff) * PROD_W'(ks);
      e_pr_in = PROD_W'(d_r_ff) * PROD_W'(ks);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_pl_ff <= e_pl_in;
         e_pr_ff <= e_pr_in;
      end
   end

   // Round a scaled product to the output format, ties away from zero.
   function automatic logic [SPEED_W-1:0] round_out(input logic signed [PROD_W-1:0] prod);
      logic [PROD_W-1:0] mag, rnd, q;
      mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      rnd = (mag + (PROD_W'(1) << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
      q   = prod[PROD_W-1] ? -rnd : rnd;
      return q[SPEED_W-1:0];
   endfunction

   // Stage F: output register.
   logic signed [SPEED_W-1:0] f_left_ff, f_right_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         f_left_ff  <= round_out(e_pl_ff);
         f_right_ff <= round_out(e_pr_ff);
      end
   end

   assign rsp_if.valid       = valid_ff[PIPE_DEPTH-1];
   assign rsp_if.left_speed  = f_left_ff;
   assign rsp_if.right_speed = f_right_ff;

   // A result never shows in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   // A stalled pipeline keeps every transaction in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   // The finished square root fits the scale width.
   a_root_width: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ITER_STAGES+2] |-> (last.root[N_W-1:SQRT_STAGES] == '0))
      else $error("square root result overflowed");

   // Unit speeds of the segment map stay within full forward and reverse.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ITER_STAGES+3] |->
         (d_l_ff <= QUARTER_U) && (d_l_ff >= -QUARTER_U) &&
         (d_r_ff <= QUARTER_U) && (d_r_ff >= -QUARTER_U))
      else $error("unit speed out of range");

endmodule
`default_nettype wire

[tb/joystick_to_tank_drive_mixer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_to_tank_drive_mixer_unit_tb: self-checking bench for the mixer
// Drives joystick samples with random gaps, pulls track speed pairs with
// random stalls, and compares each pair with a bit-exact software mixer
// (CORDIC angle, square root scale, segment map, rounding).
// ----------------------------------------------------------------------------
module joystick_to_tank_drive_mixer_unit_tb;
   import jtm_pkg::*;

   // Mixer arithmetic constants, kept apart from the RTL's own copies.
   localparam int     MIX_STAGES   = 16;
   localparam int     MIX_FRAC     = 14;
   localparam longint QUARTER      = 64'sd1 << 30;
   localparam longint FULL_SCALE   = 64'sd1 << 24;
   localparam int     ROUND_SHIFT  = 54 - MIX_FRAC;
   localparam longint ARC_STEP [MIX_STAGES] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   localparam int RANDOM_ITEMS = 1100;
   localparam int STALL_LIMIT  = 1000;
   localparam int LONG_HOLD    = 120;

   // Corner samples: origin, full deflection in every quadrant, the axes,
   // saturation of out-of-range readings and the segment boundaries.
   localparam int CORNER_COUNT = 24;
   localparam byte CORNER_X [CORNER_COUNT] = '{
      0, 100, -100, -100, 100, 0, 0, 0, -100, -1, 100, 127,
      -128, 101, -101, -50, 50, -87, 87, -15, 30, -3, 1, -1
   };
   localparam byte CORNER_Y [CORNER_COUNT] = '{
      0, 100, 100, -100, -100, 100, -100, -1, 0, 0, 0, -128,
      127, -101, 101, -87, -87, -50, -50, -26, 40, 4, 1, -1
   };

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed;
      logic [SPEED_W-1:0] right_speed;
   } speed_pair_type;

   // Predicts the speed pair of each accepted sample and checks the results.
   class track_speed_board;
      speed_pair_type pending_speeds [$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function longint clamp_axis(logic [JOY_W-1:0] raw);
         longint v;
         v = longint'($signed(raw));
         if (v > 100) v = 100;
         if (v < -100) v = -100;
         return v;
      endfunction

      // Direction angle as a fraction of a quarter turn, in Q1.30.
      function longint angle_fraction(longint ax, longint ay);
         longint cx, cy, z, dx, dy;
         if (ax == 0) return QUARTER;
         if (ay == 0) return 0;
         cx = ax <<< 20;
         cy = ay <<< 20;
         z = 0;
         for (int i = 0; i < MIX_STAGES; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
               cx += dx;
               cy -= dy;
               z += ARC_STEP[i];
            end else begin
               cx -= dx;
               cy += dy;
               z -= ARC_STEP[i];
            end
         end
         if (z < 0) z = 0;
         if (z > QUARTER) z = QUARTER;
         return z;
      endfunction

      function longint root_floor(longint unsigned n);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return longint'(root);
      endfunction

      // Scale a unit speed by the magnitude, round half away from zero.
      function logic [SPEED_W-1:0] to_speed(longint unit_speed, longint k);
         longint        prod, q;
         longint unsigned mag;
         prod = unit_speed * k;
         mag = (prod < 0) ? longint'(-prod) : prod;
         mag = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         q = (prod < 0) ? -longint'(mag) : longint'(mag);
         return q[SPEED_W-1:0];
      endfunction

      function speed_pair_type mix_sample(logic [JOY_W-1:0] raw_x, logic [JOY_W-1:0] raw_y);
         longint         x, y, t, l, r, a, b, k, msq;
         speed_pair_type pair;
         x = clamp_axis(raw_x);
         y = clamp_axis(raw_y);
         t = angle_fraction((x < 0) ? -x : x, (y < 0) ? -y : y);
         if (y >= 0) begin
            l = (x >= 0) ? QUARTER : 2 * t - QUARTER;
            r = (x >= 0) ? 2 * t - QUARTER : QUARTER;
         end else begin
            // Lower half: pivot reverse, one track stopped, then full reverse.
            if (3 * t < QUARTER) begin
               a = 3 * t - QUARTER;
               b = QUARTER - 3 * t;
            end else if (3 * t < 2 * QUARTER) begin
               a = 0;
               b = QUARTER - 3 * t;
            end else begin
               a = 2 * QUARTER - 3 * t;
               b = -QUARTER;
            end
            l = (x <= 0) ? a : b;
            r = (x <= 0) ? b : a;
         end
         msq = x * x + y * y;
         k = (msq >= 10000) ? FULL_SCALE : root_floor((msq << 44) / 625);
         pair.left_speed = to_speed(l, k);
         pair.right_speed = to_speed(r, k);
         return pair;
      endfunction

      function void add_sample(logic [JOY_W-1:0] raw_x, logic [JOY_W-1:0] raw_y);
         pending_speeds.push_back(mix_sample(raw_x, raw_y));
      endfunction

      function void check_pair(logic [SPEED_W-1:0] left_got, logic [SPEED_W-1:0] right_got);
         speed_pair_type want;
         if (pending_speeds.size() == 0) begin
            $error("speed pair left=%0d right=%0d with no sample outstanding",
                   $signed(left_got), $signed(right_got));
            mismatches++;
            return;
         end
         want = pending_speeds.pop_front();
         if (left_got !== want.left_speed) begin
            $error("left_speed: expected %0d, got %0d",
                   $signed(want.left_speed), $signed(left_got));
            mismatches++;
         end
         if (right_got !== want.right_speed) begin
            $error("right_speed: expected %0d, got %0d",
                   $signed(want.right_speed), $signed(right_got));
            mismatches++;
         end
      endfunction

      function int pending_count();
         return pending_speeds.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   reset_done = 1'b0;
   bit   send_idle = 1'b1;
   bit   rsp_idle = 1'b1;
   bit   hold_long = 1'b0;
   int   quiet_cycles = 0;

   track_speed_board board;

   jtm_req_if req ();
   jtm_rsp_if rsp ();

   joystick_to_tank_drive_mixer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one sample after a random gap and hold it until the transaction.
   task automatic send_sample(logic [JOY_W-1:0] x, logic [JOY_W-1:0] y);
      int gap;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.joy_x = x;
      req.joy_y = y;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.add_sample(x, y);
      @(negedge clock);
   endtask

   // Stop offering samples until every outstanding pair has come back.
   task automatic drain_results();
      req.valid = 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly legal deflections, some tiny ones and some raw bytes.
   function automatic logic [JOY_W-1:0] draw_axis();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return JOY_W'($urandom_range(0, 255));
      if (pick == 1) return JOY_W'($urandom_range(0, 20) - 10);
      return JOY_W'($urandom_range(0, 200) - 100);
   endfunction

   // Sample stream.
   initial begin
      board = new();
      req.valid = 1'b0;
      req.joy_x = '0;
      req.joy_y = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      reset_done = 1'b1;

      for (int i = 0; i < CORNER_COUNT; i++) begin
         send_sample(CORNER_X[i], CORNER_Y[i]);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Back-to-back samples against a long result stall fill the pipe.
         if (n == 300) begin
            hold_long = 1'b1;
            send_idle = 1'b0;
         end
         if (n == 500) send_idle = 1'b1;
         if (n == 550) begin
            drain_results();
            send_idle = 1'b0;
            rsp_idle = 1'b0;
         end
         if (n == 800) begin
            send_idle = 1'b1;
            rsp_idle = 1'b1;
         end
         send_sample(draw_axis(), draw_axis());
      end

      drain_results();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (board.pending_count() != 0) begin
         $error("%0d speed pairs never arrived", board.pending_count());
         board.mismatches++;
      end
      if (board.mismatches == 0) begin
         $display("[joystick_to_tank_drive_mixer_unit] OK");
      end else begin
         $display("[joystick_to_tank_drive_mixer_unit] ERROR");
      end
      $finish;
   end

   // Speed pair sink with random stalls and one long hold-off.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      while (!reset_done) @(negedge clock);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 6) : 0;
         if (hold_long) begin
            stall = LONG_HOLD;
            hold_long = 1'b0;
         end
         if (stall > 0) begin
            rsp.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready = 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         board.check_pair(rsp.left_speed, rsp.right_speed);
         @(negedge clock);
      end
   end

   // Watchdog: too long without any transaction on either side.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("[joystick_to_tank_drive_mixer_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[sim.f]
design/jtm_pkg.sv
design/jtm_if.sv
design/joystick_to_tank_drive_mixer_unit.sv
tb/joystick_to_tank_drive_mixer_unit_tb.sv
